>>> hdl/rbl_pkg.sv
// Package for the ranked byte list: operation, status and cell command codes,
// plus the control word that the top level broadcasts to every list cell.
// No dependencies.
package rbl_pkg;

	localparam int BYTE_W = 8;
	localparam int RANK_W = 8;

	// Operation codes carried on the slave-side tuser.
	localparam logic [1:0] OP_ADD    = 2'd0;
	localparam logic [1:0] OP_DELETE = 2'd1;
	localparam logic [1:0] OP_GET    = 2'd2;
	localparam logic [1:0] OP_PRINT  = 2'd3;

	// Result status codes.
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_BADPOS = 2'd1;
	localparam logic [1:0] ST_FULL   = 2'd2;

	// Per-cycle command to the cell chain.
	typedef logic [1:0] cell_cmd_t;
	localparam cell_cmd_t CMD_HOLD   = 2'd0;
	localparam cell_cmd_t CMD_INSERT = 2'd1;
	localparam cell_cmd_t CMD_REMOVE = 2'd2;
	localparam cell_cmd_t CMD_ROTATE = 2'd3;

	typedef struct packed {
		cell_cmd_t           cmd;
		logic [RANK_W-1:0]   pos;       // zero-based position of the operation
		logic [RANK_W-1:0]   last_idx;  // index of the last occupied cell
	} cell_ctrl_t;

endpackage

>>> hdl/ranked_byte_list.sv
// Top level of the ranked byte list: a chain of rbl_cell instances, the rank
// checks, the print sequencer and the registered result stage.
// Depends on rbl_pkg and rbl_cell.

// The block keeps an ordered list of up to CAPACITY bytes addressed by a
// one-based rank. Each input transfer carries an operation on s_axis_tuser
// (add, delete, get, print) with the rank and the byte on s_axis_tdata. Every
// list byte lives in its own cell of a chain; an add shifts the cells at and
// above the rank one place up, a delete shifts them one place down, and a
// get picks the addressed cell off an OR-combined read bus. Add, delete and
// get each produce one result transfer, registered and presented in the cycle
// after acceptance; they can follow each other in every cycle as long as the
// master side keeps taking results. Print rotates the occupied part of the
// chain once per cycle and emits the head cell each time, so it occupies the
// block from the accepting cycle until every byte has been emitted (on an
// empty list it gives at once one result without a byte). No input transfer
// is accepted until the final byte, marked by m_axis_tlast, has been loaded
// into the result register. A stall on the master side stalls the rotation.
// Result status is 0 for success, 1 for a rank out of range and 2 for an add
// to a full list; a bad rank takes precedence over a full list. Unoccupied
// cells have no reset value and are never returned.
module ranked_byte_list #(
	parameter int CAPACITY = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // [7:0] rank, [15:8] element
	input  logic [1:0]  s_axis_tuser,   // [1:0] operation
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [1:0] status, [9:2] value, [15:10] zero
	output logic [0:0]  m_axis_tuser,   // [0] has_element
	output logic        m_axis_tlast
);
	import rbl_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);

	localparam logic       ST_IDLE  = 1'b0;
	localparam logic       ST_PRINT = 1'b1;

	// Input fields.
	logic [1:0]        operation;
	logic [RANK_W-1:0] rank;
	logic [BYTE_W-1:0] element;

	assign operation = s_axis_tuser;
	assign rank      = s_axis_tdata[7:0];
	assign element   = s_axis_tdata[15:8];

	// Control state.
	logic          state_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] left_q;

	// Result register.
	logic              out_valid_q;
	logic [1:0]        out_status_q;
	logic              out_has_q;
	logic [BYTE_W-1:0] out_value_q;
	logic              out_last_q;

	// Cell chain.
	cell_ctrl_t        ctrl;
	logic [BYTE_W-1:0] cell_q   [CAPACITY];
	logic [BYTE_W-1:0] cell_sel [CAPACITY];
	logic [BYTE_W-1:0] get_value;

	// Handshake and decode.
	logic        out_free;
	logic        in_fire;
	logic [8:0]  rank9;
	logic [8:0]  count9;
	logic        bad_add;
	logic        bad_rd;
	logic        is_full;

	logic              out_load;
	logic [1:0]        nxt_status;
	logic              nxt_has;
	logic [BYTE_W-1:0] nxt_value;
	logic              nxt_last;

	assign out_free      = !out_valid_q || m_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE) && out_free;
	assign in_fire       = s_axis_tvalid && s_axis_tready;

	assign rank9   = {1'b0, rank};
	assign count9  = 9'(count_q);
	assign bad_add = (rank == '0) || (rank9 > count9 + 9'd1);
	assign bad_rd  = (rank == '0) || (rank9 > count9);
	assign is_full = (count9 == 9'(CAPACITY));

	// The read bus: only the addressed cell drives a nonzero byte.
	always_comb begin
		get_value = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			get_value = get_value | cell_sel[i];
		end
	end

	// Command to the chain. It depends only on the handshake, the state, the
	// operation and the rank and fill checks, never on the read bus that the cells drive back.
	always_comb begin
		ctrl.cmd      = CMD_HOLD;
		ctrl.pos      = rank - RANK_W'(1);
		ctrl.last_idx = RANK_W'(count_q) - RANK_W'(1);

		if (state_q == ST_PRINT) begin
			if (out_free) begin
				ctrl.cmd = CMD_ROTATE;
			end
		end else if (in_fire) begin
			unique case (operation)
				OP_ADD: begin
					if (!bad_add && !is_full) begin
						ctrl.cmd = CMD_INSERT;
					end
				end
				OP_DELETE: begin
					if (!bad_rd) begin
						ctrl.cmd = CMD_REMOVE;
					end
				end
				default: begin
					ctrl.cmd = CMD_HOLD;
				end
			endcase
		end
	end

	// The next result.
	always_comb begin
		out_load      = 1'b0;
		nxt_status    = ST_OK;
		nxt_has       = 1'b0;
		nxt_value     = '0;
		nxt_last      = 1'b1;

		if (state_q == ST_PRINT) begin
			if (out_free) begin
				out_load  = 1'b1;
				nxt_has   = 1'b1;
				nxt_value = cell_q[0];
				nxt_last  = (left_q == CW'(1));
			end
		end else if (in_fire) begin
			unique case (operation)
				OP_ADD: begin
					out_load = 1'b1;
					if (bad_add) begin
						nxt_status = ST_BADPOS;
					end else if (is_full) begin
						nxt_status = ST_FULL;
					end
				end
				OP_DELETE: begin
					out_load = 1'b1;
					if (bad_rd) begin
						nxt_status = ST_BADPOS;
					end
				end
				OP_GET: begin
					out_load = 1'b1;
					if (bad_rd) begin
						nxt_status = ST_BADPOS;
					end else begin
						nxt_has   = 1'b1;
						nxt_value = get_value;
					end
				end
				OP_PRINT: begin
					// An empty list answers at once; otherwise the sequencer
					// takes over from the next cycle.
					out_load = (count_q == '0);
				end
				default: begin
					out_load = 1'b0;
				end
			endcase
		end
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			left_q  <= '0;
		end else begin
			if (state_q == ST_PRINT) begin
				if (out_free) begin
					left_q <= left_q - CW'(1);
					if (left_q == CW'(1)) begin
						state_q <= ST_IDLE;
					end
				end
			end else if (in_fire) begin
				if (ctrl.cmd == CMD_INSERT) begin
					count_q <= count_q + CW'(1);
				end else if (ctrl.cmd == CMD_REMOVE) begin
					count_q <= count_q - CW'(1);
				end else if (operation == OP_PRINT && count_q != '0) begin
					state_q <= ST_PRINT;
					left_q  <= count_q;
				end
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_status_q <= nxt_status;
			out_has_q    <= nxt_has;
			out_value_q  <= nxt_value;
			out_last_q   <= nxt_last;
		end
	end

	assign m_axis_tvalid   = out_valid_q;
	assign m_axis_tdata    = {6'd0, out_value_q, out_status_q};
	assign m_axis_tuser[0] = out_has_q;
	assign m_axis_tlast    = out_last_q;

	// The chain: each cell sees its neighbors, the head cell and the new byte.
	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic [BYTE_W-1:0] left_d;
		logic [BYTE_W-1:0] right_d;

		if (g == 0) begin : g_first
			assign left_d = element;
		end else begin : g_inner_l
			assign left_d = cell_q[g-1];
		end

		if (g == CAPACITY - 1) begin : g_end
			assign right_d = cell_q[g];
		end else begin : g_inner_r
			assign right_d = cell_q[g+1];
		end

		rbl_cell #(
			.INDEX(g)
		) u_cell (
			.clk   (clk),
			.ctrl  (ctrl),
			.elem  (element),
			.left  (left_d),
			.right (right_d),
			.head  (cell_q[0]),
			.q     (cell_q[g]),
			.sel   (cell_sel[g])
		);
	end

	// The list never grows past its capacity.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		9'(count_q) <= 9'(CAPACITY))
		else $error("list count above capacity");

	// The list length moves only when an input transfer is taken.
	a_count_moves_on_input: assert property (@(posedge clk) disable iff (!arst_n)
		!in_fire |=> $stable(count_q))
		else $error("list count changed without an input transfer");

	// A print in progress always has entries left to emit.
	a_print_left: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PRINT) |-> (left_q != '0))
		else $error("print sequencer running with nothing left");

	// Loading the final print byte ends the print and marks it last.
	a_print_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PRINT && out_free && left_q == CW'(1))
		|=> (state_q == ST_IDLE && out_valid_q && out_last_q))
		else $error("print did not close with a last result");

endmodule

>>> hdl/rbl_cell.sv
// One cell of the ranked byte list chain: holds a single list byte and takes
// a new one from its left or right neighbor, the head cell or the input byte.
// Depends on rbl_pkg.
module rbl_cell #(
	parameter int INDEX = 0
) (
	input  logic                            clk,
	input  rbl_pkg::cell_ctrl_t             ctrl,
	input  logic [rbl_pkg::BYTE_W-1:0]      elem,
	input  logic [rbl_pkg::BYTE_W-1:0]      left,
	input  logic [rbl_pkg::BYTE_W-1:0]      right,
	input  logic [rbl_pkg::BYTE_W-1:0]      head,
	output logic [rbl_pkg::BYTE_W-1:0]      q,
	output logic [rbl_pkg::BYTE_W-1:0]      sel
);
	import rbl_pkg::*;

	localparam logic [RANK_W-1:0] IDX = RANK_W'(INDEX);

	logic [BYTE_W-1:0] data_q;
	logic [BYTE_W-1:0] d;

	always_comb begin
		d = data_q;
		unique case (ctrl.cmd)
			CMD_INSERT: begin
				if (IDX == ctrl.pos) begin
					d = elem;
				end else if (IDX > ctrl.pos) begin
					d = left;
				end
			end
			CMD_REMOVE: begin
				if (IDX >= ctrl.pos) begin
					d = right;
				end
			end
			CMD_ROTATE: begin
				d = (IDX == ctrl.last_idx) ? head : right;
			end
			default: begin
				d = data_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		data_q <= d;
	end

	assign q   = data_q;
	// Only the addressed cell drives its byte onto the read bus.
	assign sel = (IDX == ctrl.pos) ? data_q : '0;

endmodule
